FILE: design/nvmf_pkg.sv
// Shared widths, constants and command codes for the negative value mass filler.
// No dependencies; every other file refers to it by scoped names.
package nvmf_pkg;

    localparam int VALUE_BITS = 32;
    localparam int SUM_BITS   = 48;
    localparam int FRAC_BITS  = 16;

    localparam int RATIO_BITS = FRAC_BITS + 1;
    localparam int OUT_BITS   = VALUE_BITS - 1;
    localparam int CNT_BITS   = $clog2(FRAC_BITS + 1);

    localparam logic [RATIO_BITS-1:0] RATIO_ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [SUM_BITS-1:0]   SUM_MAX   = {SUM_BITS{1'b1}};

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_CLOSE = 2'd2,
        OP_APPLY = 2'd3
    } op_t;

    typedef struct packed {
        logic clear;
        logic add;
    } acc_cmd_t;

    typedef struct packed {
        logic                  busy;
        logic                  scale_enable;
        logic [RATIO_BITS-1:0] ratio;
    } div_stat_t;

endpackage

FILE: design/negative_value_mass_filler_unit.sv
// Negative value filler with mass conservation: top level, command decode,
// apply multiplier and result register. Depends on nvmf_pkg, nvmf_acc, nvmf_div.
//
// Usage: stream the field twice. First pass sends add beats (op 1), then one
// close beat (op 2); second pass sends apply beats (op 3). Clear (op 0) zeroes
// the sums. Input channel s_valid/s_ready with s_op, s_value; result channel
// m_valid/m_ready with m_kind, m_corrected_value, m_scale_applied, m_ratio.
// Clear and add beats give no result and are taken one per cycle, even while
// a result waits on the output. An apply beat is taken whenever the result
// register is empty or being drained; its result appears on the next cycle.
// A close beat runs the divider, one quotient bit per cycle, when a scaling
// division is needed; the unit then waits in ST_DIV until the divider is
// done and in ST_OUT until the result register is free, and s_ready
// stays low meanwhile. A stalled receiver holds the result register and
// blocks apply and close beats. Reset (aresetn low, synchronous) zeroes the
// sums, turns scaling off with ratio one and empties the result register.
module negative_value_mass_filler_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_op,
    input  logic signed [nvmf_pkg::VALUE_BITS-1:0] s_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_kind,
    output logic [nvmf_pkg::OUT_BITS-1:0]     m_corrected_value,
    output logic                              m_scale_applied,
    output logic [nvmf_pkg::RATIO_BITS-1:0]   m_ratio
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } state_t;

    localparam logic KIND_CLOSE = 1'b0;
    localparam logic KIND_VALUE = 1'b1;

    state_t                                state_reg, state_next;
    logic                                  vld_reg, vld_next;
    logic                                  kind_reg, kind_next;
    logic [nvmf_pkg::OUT_BITS-1:0]         val_reg, val_next;
    logic                                  scl_reg, scl_next;
    logic [nvmf_pkg::RATIO_BITS-1:0]       rat_reg, rat_next;

    nvmf_pkg::op_t                         op;
    nvmf_pkg::acc_cmd_t                    acc_cmd;
    nvmf_pkg::div_stat_t                   dstat;
    logic [nvmf_pkg::SUM_BITS-1:0]         pos_sum;
    logic [nvmf_pkg::SUM_BITS-1:0]         neg_sum;
    logic                                  out_free;
    logic                                  accept;
    logic                                  div_start;
    logic [nvmf_pkg::OUT_BITS-1:0]         mag;
    logic [nvmf_pkg::OUT_BITS+nvmf_pkg::RATIO_BITS-1:0] prod;
    logic [nvmf_pkg::OUT_BITS-1:0]         fixed;

    nvmf_acc u_acc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (acc_cmd),
        .value   (s_value),
        .pos_sum (pos_sum),
        .neg_sum (neg_sum)
    );

    nvmf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .pos_sum (pos_sum),
        .neg_sum (neg_sum),
        .stat    (dstat)
    );

    always_comb begin
        op       = nvmf_pkg::op_t'(s_op);
        out_free = !vld_reg || m_ready;

        case (op)
            nvmf_pkg::OP_CLEAR,
            nvmf_pkg::OP_ADD:   s_ready = (state_reg == ST_IDLE);
            default:            s_ready = (state_reg == ST_IDLE) && out_free;
        endcase
        accept = s_valid && s_ready;

        acc_cmd.clear = accept && (op == nvmf_pkg::OP_CLEAR);
        acc_cmd.add   = accept && (op == nvmf_pkg::OP_ADD);
        div_start     = accept && (op == nvmf_pkg::OP_CLOSE);

        // ratio never exceeds one, so the product keeps the value's width
        mag   = s_value[nvmf_pkg::OUT_BITS-1:0];
        prod  = mag * dstat.ratio;
        fixed = dstat.scale_enable
              ? prod[nvmf_pkg::FRAC_BITS+nvmf_pkg::OUT_BITS-1:nvmf_pkg::FRAC_BITS]
              : mag;

        state_next = state_reg;
        vld_next   = vld_reg && !m_ready;
        kind_next  = kind_reg;
        val_next   = val_reg;
        scl_next   = scl_reg;
        rat_next   = rat_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept && (op == nvmf_pkg::OP_APPLY)) begin
                    vld_next  = 1'b1;
                    kind_next = KIND_VALUE;
                    val_next  = s_value[nvmf_pkg::VALUE_BITS-1] ? '0 : fixed;
                    scl_next  = dstat.scale_enable;
                    rat_next  = dstat.ratio;
                end else if (div_start) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!dstat.busy) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // hold the close result until the output slot frees up
                if (out_free) begin
                    vld_next   = 1'b1;
                    kind_next  = KIND_CLOSE;
                    val_next   = '0;
                    scl_next   = dstat.scale_enable;
                    rat_next   = dstat.ratio;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            vld_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            vld_reg   <= vld_next;
        end
        kind_reg <= kind_next;
        val_reg  <= val_next;
        scl_reg  <= scl_next;
        rat_reg  <= rat_next;
    end

    assign m_valid           = vld_reg;
    assign m_kind            = kind_reg;
    assign m_corrected_value = val_reg;
    assign m_scale_applied   = scl_reg;
    assign m_ratio           = rat_reg;

    a_div_only_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        dstat.busy |-> (state_reg == ST_DIV))
        else $error("divider running outside the close sequence");

    a_ratio_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_ratio <= nvmf_pkg::RATIO_ONE))
        else $error("result ratio above one");

    a_unscaled_ratio_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_scale_applied) |-> (m_ratio == nvmf_pkg::RATIO_ONE))
        else $error("scaling off but ratio differs from one");

    a_close_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind == KIND_CLOSE)) |-> (m_corrected_value == '0))
        else $error("close result carries a nonzero value");

endmodule

FILE: design/nvmf_acc.sv
// Saturating accumulators for the positive sum and the negative magnitude sum.
// Depends on nvmf_pkg.
module nvmf_acc (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  nvmf_pkg::acc_cmd_t                cmd,
    input  logic [nvmf_pkg::VALUE_BITS-1:0]   value,
    output logic [nvmf_pkg::SUM_BITS-1:0]     pos_sum,
    output logic [nvmf_pkg::SUM_BITS-1:0]     neg_sum
);

    logic [nvmf_pkg::SUM_BITS-1:0]   pos_reg, pos_next;
    logic [nvmf_pkg::SUM_BITS-1:0]   neg_reg, neg_next;
    logic                            is_neg;
    logic [nvmf_pkg::VALUE_BITS-1:0] mag;
    logic [nvmf_pkg::SUM_BITS-1:0]   base;
    logic [nvmf_pkg::SUM_BITS:0]     total;
    logic [nvmf_pkg::SUM_BITS-1:0]   sat;

    // one adder serves both sums; the sign picks the operand
    always_comb begin
        is_neg = value[nvmf_pkg::VALUE_BITS-1];
        mag    = is_neg ? (~value + 1'b1) : value;
        base   = is_neg ? neg_reg : pos_reg;
        total  = {1'b0, base}
               + {{(nvmf_pkg::SUM_BITS + 1 - nvmf_pkg::VALUE_BITS){1'b0}}, mag};
        sat    = total[nvmf_pkg::SUM_BITS] ? nvmf_pkg::SUM_MAX
                                           : total[nvmf_pkg::SUM_BITS-1:0];
        pos_next = pos_reg;
        neg_next = neg_reg;
        if (cmd.clear) begin
            pos_next = '0;
            neg_next = '0;
        end else if (cmd.add) begin
            if (is_neg) begin
                neg_next = sat;
            end else begin
                pos_next = sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            neg_reg <= '0;
        end else begin
            pos_reg <= pos_next;
            neg_reg <= neg_next;
        end
    end

    assign pos_sum = pos_reg;
    assign neg_sum = neg_reg;

endmodule

FILE: design/nvmf_div.sv
// Bit-serial ratio divider: floor((pos - neg) * 2^F / pos), one quotient bit a cycle.
// Holds scale enable and ratio between closes. Depends on nvmf_pkg.
module nvmf_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [nvmf_pkg::SUM_BITS-1:0] pos_sum,
    input  logic [nvmf_pkg::SUM_BITS-1:0] neg_sum,
    output nvmf_pkg::div_stat_t           stat
);

    typedef enum logic {
        D_IDLE,
        D_RUN
    } dstate_t;

    dstate_t                               state_reg, state_next;
    logic [nvmf_pkg::SUM_BITS-1:0]         rem_reg, rem_next;
    logic [nvmf_pkg::SUM_BITS-1:0]         den_reg, den_next;
    logic [nvmf_pkg::FRAC_BITS-1:0]        quo_reg, quo_next;
    logic [nvmf_pkg::CNT_BITS-1:0]         cnt_reg, cnt_next;
    logic                                  en_reg, en_next;
    logic [nvmf_pkg::RATIO_BITS-1:0]       ratio_reg, ratio_next;
    logic [nvmf_pkg::SUM_BITS:0]           diff;
    logic [nvmf_pkg::SUM_BITS+1:0]         dbl;
    logic [nvmf_pkg::SUM_BITS+1:0]         trial;

    always_comb begin
        // separate subtractors: pos - neg at start, 2*rem - den while running
        diff  = {1'b0, pos_sum} - {1'b0, neg_sum};
        dbl   = {1'b0, rem_reg, 1'b0};
        trial = dbl - {2'b00, den_reg};

        state_next = state_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        en_next    = en_reg;
        ratio_next = ratio_reg;

        case (state_reg)
            D_IDLE: begin
                if (start) begin
                    if ((pos_sum == '0) || diff[nvmf_pkg::SUM_BITS]) begin
                        en_next    = 1'b0;
                        ratio_next = nvmf_pkg::RATIO_ONE;
                    end else if (neg_sum == '0) begin
                        en_next    = 1'b1;
                        ratio_next = nvmf_pkg::RATIO_ONE;
                    end else begin
                        en_next    = 1'b1;
                        rem_next   = diff[nvmf_pkg::SUM_BITS-1:0];
                        den_next   = pos_sum;
                        quo_next   = '0;
                        cnt_next   = '0;
                        state_next = D_RUN;
                    end
                end
            end
            D_RUN: begin
                if (!trial[nvmf_pkg::SUM_BITS+1]) begin
                    rem_next = trial[nvmf_pkg::SUM_BITS-1:0];
                    quo_next = {quo_reg[nvmf_pkg::FRAC_BITS-2:0], 1'b1};
                end else begin
                    rem_next = dbl[nvmf_pkg::SUM_BITS-1:0];
                    quo_next = {quo_reg[nvmf_pkg::FRAC_BITS-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == nvmf_pkg::CNT_BITS'(nvmf_pkg::FRAC_BITS - 1)) begin
                    ratio_next = {1'b0, quo_next};
                    state_next = D_IDLE;
                end
            end
            default: begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            en_reg    <= 1'b0;
            ratio_reg <= nvmf_pkg::RATIO_ONE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            en_reg    <= en_next;
            ratio_reg <= ratio_next;
            cnt_reg   <= cnt_next;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign stat.busy         = (state_reg == D_RUN);
    assign stat.scale_enable = en_reg;
    assign stat.ratio        = ratio_reg;

endmodule

FILE: sim/tb_negative_value_mass_filler_unit.sv
// Self-checking testbench for negative_value_mass_filler_unit: drives add, clear,
// close and apply beats, predicts each result and checks it on the result channel.
// Depends on nvmf_pkg and the negative_value_mass_filler_unit RTL.
module tb_negative_value_mass_filler_unit;

    localparam logic KIND_CLOSE = 1'b0;
    localparam logic KIND_VALUE = 1'b1;

    localparam logic signed [nvmf_pkg::VALUE_BITS-1:0] VALUE_MAX =
        {1'b0, {(nvmf_pkg::VALUE_BITS-1){1'b1}}};
    localparam logic signed [nvmf_pkg::VALUE_BITS-1:0] VALUE_MIN =
        {1'b1, {(nvmf_pkg::VALUE_BITS-1){1'b0}}};

    localparam int CYCLE_LIMIT  = 200_000;
    localparam int TAIL_CYCLES  = 40;
    localparam int LARGE_BEATS  = 50;   // max-magnitude beats to push the sums high
    localparam int RANDOM_BEATS = 150;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic                            kind;
        logic [nvmf_pkg::OUT_BITS-1:0]   value;
        logic                            scaled;
        logic [nvmf_pkg::RATIO_BITS-1:0] ratio;
    } fill_result_t;

    logic                                  aclk    = 1'b0;
    logic                                  aresetn = 1'b0;
    logic                                  s_valid = 1'b0;
    logic                                  s_ready;
    logic [1:0]                            s_op    = nvmf_pkg::OP_CLEAR;
    logic signed [nvmf_pkg::VALUE_BITS-1:0] s_value = '0;
    logic                                  m_valid;
    logic                                  m_ready = 1'b0;
    logic                                  m_kind;
    logic [nvmf_pkg::OUT_BITS-1:0]         m_corrected_value;
    logic                                  m_scale_applied;
    logic [nvmf_pkg::RATIO_BITS-1:0]       m_ratio;

    // predictor state
    logic [nvmf_pkg::SUM_BITS-1:0]   pos_mass    = '0;
    logic [nvmf_pkg::SUM_BITS-1:0]   neg_mass    = '0;
    logic [nvmf_pkg::RATIO_BITS-1:0] fill_ratio  = nvmf_pkg::RATIO_ONE;
    logic                            fill_scaled = 1'b0;

    fill_result_t pending_fills[$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_cycles    = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int mismatch_count = 0;

    negative_value_mass_filler_unit uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_value           (s_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_corrected_value (m_corrected_value),
        .m_scale_applied   (m_scale_applied),
        .m_ratio           (m_ratio)
    );

    always #1 aclk = ~aclk;

    function automatic logic [nvmf_pkg::SUM_BITS-1:0] sat_accumulate(
        input logic [nvmf_pkg::SUM_BITS-1:0]   acc,
        input logic [nvmf_pkg::VALUE_BITS-1:0] x);
        logic [nvmf_pkg::SUM_BITS:0] wide;
        wide = {1'b0, acc} + (nvmf_pkg::SUM_BITS+1)'(x);
        return (wide > {1'b0, nvmf_pkg::SUM_MAX}) ? nvmf_pkg::SUM_MAX
                                                   : wide[nvmf_pkg::SUM_BITS-1:0];
    endfunction

    // Update the mass sums and scaling state for one beat, queue its result if any.
    task automatic account_fill(input nvmf_pkg::op_t op,
                                input logic signed [nvmf_pkg::VALUE_BITS-1:0] v);
        logic [nvmf_pkg::VALUE_BITS-1:0] mag;
        logic [63:0]                     wide;
        fill_result_t                    r;
        mag = ~v + 1'b1;
        case (op)
            nvmf_pkg::OP_CLEAR: begin
                pos_mass = '0;
                neg_mass = '0;
            end
            nvmf_pkg::OP_ADD: begin
                if (v < 0)
                    neg_mass = sat_accumulate(neg_mass, mag);
                else
                    pos_mass = sat_accumulate(pos_mass, v);
            end
            nvmf_pkg::OP_CLOSE: begin
                if (pos_mass != 0 && neg_mass <= pos_mass) begin
                    fill_scaled = 1'b1;
                    wide = (64'(pos_mass - neg_mass) << nvmf_pkg::FRAC_BITS)
                         / 64'(pos_mass);
                    fill_ratio = wide[nvmf_pkg::RATIO_BITS-1:0];
                end else begin
                    fill_scaled = 1'b0;
                    fill_ratio = nvmf_pkg::RATIO_ONE;
                end
                r = '{kind: KIND_CLOSE, value: '0, scaled: fill_scaled, ratio: fill_ratio};
                pending_fills.push_back(r);
            end
            default: begin
                r = '{kind: KIND_VALUE, value: '0, scaled: fill_scaled, ratio: fill_ratio};
                if (v >= 0) begin
                    if (fill_scaled) begin
                        wide = (64'(v) * 64'(fill_ratio)) >> nvmf_pkg::FRAC_BITS;
                        r.value = wide[nvmf_pkg::OUT_BITS-1:0];
                    end else begin
                        r.value = v[nvmf_pkg::OUT_BITS-1:0];
                    end
                end
                pending_fills.push_back(r);
            end
        endcase
    endtask

    // Offer one beat; valid stays up from the previous beat when there is no gap.
    task automatic send_beat(input nvmf_pkg::op_t op,
                             input logic signed [nvmf_pkg::VALUE_BITS-1:0] v);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_op    = op;
        s_value = v;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        account_fill(op, v);
    endtask

    task automatic pause_until_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_fills.size() != 0) @(posedge aclk);
    endtask

    // Ask the sink process to hold m_ready low for a number of cycles.
    task automatic hold_sink(input int cycles);
        hold_cycles = cycles;
        hold_requests++;
    endtask

    function automatic logic signed [nvmf_pkg::VALUE_BITS-1:0] pick_value(
        input int unsigned flavor);
        case (flavor)
            0: return $urandom;
            1: return $urandom_range(4096, 0);
            2: return -$signed($urandom_range(4096, 1));
            3: begin
                case ($urandom_range(3))
                    0: return VALUE_MAX;
                    1: return VALUE_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            4: return {1'b0, (nvmf_pkg::VALUE_BITS-1)'($urandom)};
            default: return {1'b1, (nvmf_pkg::VALUE_BITS-1)'($urandom)};
        endcase
    endfunction

    // Skew picks how heavy the negatives are relative to the positives.
    function automatic logic signed [nvmf_pkg::VALUE_BITS-1:0] pick_add_value(
        input int unsigned skew);
        if ($urandom_range(1))
            return $urandom_range(1) ? {1'b0, (nvmf_pkg::VALUE_BITS-1)'($urandom)}
                                     : $urandom_range(65535, 0);
        case (skew)
            0: return -$signed($urandom_range(255, 1));
            1: return -$signed($urandom_range(65535, 1));
            default: return {1'b1, (nvmf_pkg::VALUE_BITS-1)'($urandom)};
        endcase
    endfunction

    always @(negedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_left   = hold_cycles;
            hold_served = hold_requests;
        end
        if (hold_left > 0) begin
            m_ready = 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_ready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin : check_fills
        fill_result_t want;
        if (aresetn === 1'b1 && m_valid && m_ready) begin
            if (pending_fills.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected beat: kind %0d value %0d scaled %0d ratio %0d",
                             m_kind, m_corrected_value, m_scale_applied, m_ratio);
            end else begin
                want = pending_fills.pop_front();
                if (m_kind !== want.kind || m_corrected_value !== want.value ||
                    m_scale_applied !== want.scaled || m_ratio !== want.ratio) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"bad beat: kind %0d/%0d value %0d/%0d scaled %0d/%0d ",
                                  "ratio %0d/%0d (expected/actual)"},
                                 want.kind, m_kind, want.value, m_corrected_value,
                                 want.scaled, m_scale_applied, want.ratio, m_ratio);
                end
            end
        end
    end

    // Scaling is off out of reset: positives pass, negatives go to zero.
    task automatic test_apply_before_close();
        send_beat(nvmf_pkg::OP_APPLY, 12345);
        send_beat(nvmf_pkg::OP_APPLY, -7);
        send_beat(nvmf_pkg::OP_APPLY, 0);
        send_beat(nvmf_pkg::OP_APPLY, VALUE_MAX);
        send_beat(nvmf_pkg::OP_APPLY, VALUE_MIN);
    endtask

    task automatic test_close_rules();
        send_beat(nvmf_pkg::OP_CLOSE, 0);              // empty sums: off
        send_beat(nvmf_pkg::OP_ADD, 1000);
        send_beat(nvmf_pkg::OP_ADD, -250);
        send_beat(nvmf_pkg::OP_CLOSE, 0);              // three quarters
        send_beat(nvmf_pkg::OP_APPLY, 1000);
        send_beat(nvmf_pkg::OP_APPLY, VALUE_MAX);
        send_beat(nvmf_pkg::OP_APPLY, 1);
        send_beat(nvmf_pkg::OP_CLOSE, 0);              // sums survive a close
        send_beat(nvmf_pkg::OP_CLEAR, VALUE_MIN);
        send_beat(nvmf_pkg::OP_CLOSE, 0);              // cleared: off again
        send_beat(nvmf_pkg::OP_ADD, VALUE_MAX);
        send_beat(nvmf_pkg::OP_ADD, VALUE_MIN);
        send_beat(nvmf_pkg::OP_CLOSE, 0);              // negatives outweigh positives
        send_beat(nvmf_pkg::OP_CLEAR, 0);
        send_beat(nvmf_pkg::OP_ADD, 100);
        send_beat(nvmf_pkg::OP_ADD, -100);
        send_beat(nvmf_pkg::OP_CLOSE, 0);              // exact balance: ratio zero
        send_beat(nvmf_pkg::OP_APPLY, 5);
        pause_until_drained();
    endtask

    // Drive both sums far past 32 bits with extreme values.
    task automatic test_large_sums();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        send_beat(nvmf_pkg::OP_CLEAR, 0);
        repeat (LARGE_BEATS) send_beat(nvmf_pkg::OP_ADD, VALUE_MAX);
        send_beat(nvmf_pkg::OP_CLOSE, 0);
        send_beat(nvmf_pkg::OP_APPLY, VALUE_MAX);
        repeat (LARGE_BEATS - 1) send_beat(nvmf_pkg::OP_ADD, VALUE_MIN);
        send_beat(nvmf_pkg::OP_CLOSE, 0);              // small but nonzero ratio
        send_beat(nvmf_pkg::OP_APPLY, VALUE_MAX);
        send_beat(nvmf_pkg::OP_ADD, VALUE_MIN);
        send_beat(nvmf_pkg::OP_CLOSE, 0);              // negatives just outweigh
        send_beat(nvmf_pkg::OP_APPLY, VALUE_MAX);
        send_beat(nvmf_pkg::OP_CLEAR, 0);
        pause_until_drained();
    endtask

    // Hold the result channel so apply and close beats back up at the input.
    task automatic test_backpressure();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_sink(300);
        repeat (6) send_beat(nvmf_pkg::OP_ADD, pick_add_value(1));
        repeat (4) send_beat(nvmf_pkg::OP_APPLY, pick_value($urandom_range(5)));
        send_beat(nvmf_pkg::OP_CLOSE, 0);
        repeat (8) send_beat(nvmf_pkg::OP_APPLY, pick_value($urandom_range(5)));
        send_beat(nvmf_pkg::OP_ADD, 77);
        pause_until_drained();
        hold_sink(150);
        send_beat(nvmf_pkg::OP_CLOSE, 0);
        repeat (4) send_beat(nvmf_pkg::OP_APPLY, pick_value(4));
        pause_until_drained();
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct);
        int          sent;
        int unsigned skew;
        int unsigned n;
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        sent = 0;
        while (sent < RANDOM_BEATS) begin
            if ($urandom_range(99) < 80) begin
                if ($urandom_range(3) != 0) begin
                    send_beat(nvmf_pkg::OP_CLEAR, $urandom);
                    sent++;
                end
                skew = $urandom_range(2);
                n = $urandom_range(12, 1);
                repeat (n) send_beat(nvmf_pkg::OP_ADD, pick_add_value(skew));
                send_beat(nvmf_pkg::OP_CLOSE, $urandom);
                sent += n + 1;
                n = $urandom_range(12, 1);
                repeat (n) send_beat(nvmf_pkg::OP_APPLY, pick_value($urandom_range(5)));
                sent += n;
            end else begin
                send_beat(nvmf_pkg::op_t'($urandom_range(3)),
                          pick_value($urandom_range(5)));
                sent++;
            end
        end
        pause_until_drained();
    endtask

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("negative_value_mass_filler_unit: mismatch");
        $finish;
    end

    initial begin
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        test_apply_before_close();
        test_close_rules();
        test_large_sums();
        test_backpressure();
        test_random_traffic(0, 0);
        test_random_traffic(79, 0);
        test_random_traffic(0, 79);
        test_random_traffic(29, 29);

        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("negative_value_mass_filler_unit: match");
        end else begin
            $display("negative_value_mass_filler_unit: mismatch");
        end
        $finish;
    end

endmodule
